// File: rtl/core/odo_pkg.sv
// odometry pose integrator: shared constants, command and status types, helpers
// no dependencies
package odo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int RED_STEPS    = 11;
  localparam int DIV_BITS     = 76;
  localparam int DIV_LANES    = 4;
  localparam int CNT_W        = 7;
  localparam int CFG_AW       = 3;

  localparam logic REG_RADIUS       = 1'b0;
  localparam logic REG_RAD_PER_TICK = 1'b1;

  localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
  localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
  localparam logic signed [33:0] Q28_TWO_PI  = 34'sd1686629713;
  localparam logic [41:0]        TWO_PI_W    = 42'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam int LANE_LV = 0;
  localparam int LANE_AV = 1;
  localparam int LANE_LR = 2;
  localparam int LANE_RR = 3;

  typedef enum logic [2:0] {
    MOP_WL, MOP_WR, MOP_SLO, MOP_SHI, MOP_XLO, MOP_XHI, MOP_YLO, MOP_YHI
  } mop_t;

  typedef struct packed {
    logic       load;
    logic       mul_iss;
    logic       mul_cap;
    mop_t       mop;
    logic       red_init;
    logic       red_step;
    logic [3:0] red_k;
    logic       cor_init;
    logic       cor_step;
    logic [4:0] cor_idx;
    logic       div_init;
    logic       div_step;
    logic       update;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic t_zero;
  } sts_t;

  function automatic logic [27:0] atan_q28(input logic [4:0] i);
    logic [27:0] v;
    unique case (i)
      5'd0:  v = 28'd210828714;
      5'd1:  v = 28'd124459457;
      5'd2:  v = 28'd65760959;
      5'd3:  v = 28'd33381290;
      5'd4:  v = 28'd16755422;
      5'd5:  v = 28'd8385879;
      5'd6:  v = 28'd4193963;
      5'd7:  v = 28'd2097109;
      5'd8:  v = 28'd1048571;
      5'd9:  v = 28'd524287;
      5'd10: v = 28'd262144;
      5'd11: v = 28'd131072;
      5'd12: v = 28'd65536;
      5'd13: v = 28'd32768;
      5'd14: v = 28'd16384;
      5'd15: v = 28'd8192;
      5'd16: v = 28'd4096;
      5'd17: v = 28'd2048;
      5'd18: v = 28'd1024;
      5'd19: v = 28'd512;
      5'd20: v = 28'd256;
      5'd21: v = 28'd128;
      5'd22: v = 28'd64;
      5'd23: v = 28'd32;
      5'd24: v = 28'd16;
      5'd25: v = 28'd8;
      5'd26: v = 28'd4;
      5'd27: v = 28'd2;
      5'd28: v = 28'd1;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

  // shift right toward zero
  function automatic logic signed [33:0] tshr34(input logic signed [33:0] v,
                                                input logic [4:0] sh);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : v;
    m = m >> sh;
    return v[33] ? $signed(34'(-m)) : $signed(m);
  endfunction

  // sign and magnitude to a saturated w-bit value, low bits valid
  function automatic logic [63:0] make_signed(input logic neg, input logic [75:0] mag,
                                              input logic [6:0] w);
    logic [75:0] lim;
    logic [63:0] m;
    lim = 76'd1 << (w - 7'd1);
    if (mag >= lim) begin
      m = neg ? 64'(-lim) : 64'(lim - 76'd1);
    end else begin
      m = neg ? 64'(-mag) : mag[63:0];
    end
    return m;
  endfunction

  // clamp into the signed w-bit range
  function automatic logic [63:0] sat_s(input logic signed [63:0] v, input logic [6:0] w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = $signed((64'd1 << (w - 7'd1)) - 64'd1);
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

// File: rtl/core/odo_in_if.sv
// request channel into the odometry pose integrator
// no dependencies
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        step_dt;
  logic signed [31:0] left_ticks;
  logic signed [31:0] right_ticks;
  logic signed [31:0] heading;

  modport source(output valid, step_dt, left_ticks, right_ticks, heading, input ready);
  modport sink(input valid, step_dt, left_ticks, right_ticks, heading, output ready);
endinterface

// File: rtl/core/odo_out_if.sv
// result channel out of the odometry pose integrator
// no dependencies
interface odo_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [47:0] pose_x;
  logic signed [47:0] pose_y;
  logic signed [39:0] pose_heading;
  logic signed [39:0] linear_velocity;
  logic signed [31:0] angular_velocity;
  logic signed [47:0] left_angle;
  logic signed [47:0] right_angle;
  logic signed [31:0] left_rate;
  logic signed [31:0] right_rate;

  modport source(output valid, status, pose_x, pose_y, pose_heading, linear_velocity,
                 angular_velocity, left_angle, right_angle, left_rate, right_rate,
                 input ready);
  modport sink(input valid, status, pose_x, pose_y, pose_heading, linear_velocity,
               angular_velocity, left_angle, right_angle, left_rate, right_rate,
               output ready);
endinterface

// File: rtl/core/odometry_pose_integrator.sv
// odometry pose integrator top level: register port, controller and datapath
// depends on odo_pkg, odo_in_if, odo_out_if, odo_ctrl, odo_dp
//
// Each request with a nonzero step time runs from acceptance to a valid result
// through issue/capture steps on one shared 32x32 multiplier (before and after
// the cordic), angle range reduction, one cordic load and 24 rotations, the
// four-lane restoring divider for the velocities, one state update and the
// output step. A zero step time goes from acceptance straight to the output
// step and is answered with status set and zero velocities. One request is in
// flight at a time; a finished result sits in the output register while the
// next request is taken. The wheel radius (address 0) and the tick to radians
// factor (address 4) are read back as written; the user must write them only
// while idle, which the block itself does not enforce.
module odometry_pose_integrator (
  input  logic                       clk,
  input  logic                       rst_n,
  odo_in_if.sink                     in_ch,
  odo_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [odo_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [31:0]   radius_r;
  logic [31:0]   rpt_r;
  odo_pkg::cmd_t cmd;
  odo_pkg::sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == odo_pkg::REG_RAD_PER_TICK) ? rpt_r : radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      rpt_r    <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == odo_pkg::REG_RADIUS) radius_r <= cfg_pwdata;
      else rpt_r <= cfg_pwdata;
    end
  end

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  odo_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .radius_q16       (radius_r),
    .radians_per_tick (rpt_r),
    .step_dt          (in_ch.step_dt),
    .left_ticks       (in_ch.left_ticks),
    .right_ticks      (in_ch.right_ticks),
    .heading          (in_ch.heading),
    .status           (out_ch.status),
    .pose_x           (out_ch.pose_x),
    .pose_y           (out_ch.pose_y),
    .pose_heading     (out_ch.pose_heading),
    .linear_velocity  (out_ch.linear_velocity),
    .angular_velocity (out_ch.angular_velocity),
    .left_angle       (out_ch.left_angle),
    .right_angle      (out_ch.right_angle),
    .left_rate        (out_ch.left_rate),
    .right_rate       (out_ch.right_rate)
  );

endmodule

// File: rtl/core/odo_ctrl.sv
// odometry controller: sequences multiplier, angle reduction, cordic and divider
// depends on odo_pkg
module odo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  odo_pkg::sts_t sts,
  output odo_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MISS, ST_MCAP, ST_RED, ST_CINIT, ST_CROT, ST_DIV, ST_UPD, ST_OUT
  } state_t;

  state_t                      state_r;
  logic [odo_pkg::CNT_W-1:0]   cnt_r;
  odo_pkg::mop_t               mop_r;
  logic                        out_valid_r;
  logic                        accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.mop     = mop_r;
    cmd.red_k   = 4'(odo_pkg::RED_STEPS - 1) - cnt_r[3:0];
    cmd.cor_idx = cnt_r[4:0];
    unique case (state_r)
      ST_IDLE:  cmd.load = accept;
      ST_MISS:  cmd.mul_iss = 1'b1;
      ST_MCAP: begin
        cmd.mul_cap  = 1'b1;
        cmd.red_init = (mop_r == odo_pkg::MOP_SHI);
        cmd.div_init = (mop_r == odo_pkg::MOP_YHI);
      end
      ST_RED:   cmd.red_step = 1'b1;
      ST_CINIT: cmd.cor_init = 1'b1;
      ST_CROT:  cmd.cor_step = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_UPD:   cmd.update = 1'b1;
      ST_OUT:   cmd.emit = !out_valid_r || out_ready;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      mop_r       <= odo_pkg::MOP_WL;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            mop_r   <= odo_pkg::MOP_WL;
            state_r <= sts.t_zero ? ST_OUT : ST_MISS;
          end
        end
        ST_MISS: state_r <= ST_MCAP;
        ST_MCAP: begin
          cnt_r <= '0;
          if (mop_r == odo_pkg::MOP_SHI) begin
            state_r <= ST_RED;
          end else if (mop_r == odo_pkg::MOP_YHI) begin
            state_r <= ST_DIV;
          end else begin
            mop_r   <= odo_pkg::mop_t'(mop_r + 3'd1);
            state_r <= ST_MISS;
          end
        end
        ST_RED: begin
          if (cnt_r == odo_pkg::CNT_W'(odo_pkg::RED_STEPS - 1)) begin
            state_r <= ST_CINIT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_CINIT: begin
          cnt_r   <= '0;
          state_r <= ST_CROT;
        end
        ST_CROT: begin
          if (cnt_r == odo_pkg::CNT_W'(odo_pkg::CORDIC_STEPS - 1)) begin
            mop_r   <= odo_pkg::MOP_XLO;
            state_r <= ST_MISS;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt_r == odo_pkg::CNT_W'(odo_pkg::DIV_BITS - 1)) begin
            state_r <= ST_UPD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_UPD: state_r <= ST_OUT;
        ST_OUT: begin
          if (cmd.emit) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("request taken while one is in flight");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the output step");

  a_zero_step_short: assert property (@(posedge clk) disable iff (!rst_n)
    accept && sts.t_zero |=> state_r == ST_OUT)
    else $error("zero step time did not bypass the datapath");

endmodule

// File: rtl/core/odo_dp.sv
// odometry datapath: shared multiplier, angle reduction, cordic, divider lanes, state
// depends on odo_pkg
module odo_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  odo_pkg::cmd_t       cmd,
  output odo_pkg::sts_t       sts,
  input  logic [31:0]         radius_q16,
  input  logic [31:0]         radians_per_tick,
  input  logic [31:0]         step_dt,
  input  logic signed [31:0]  left_ticks,
  input  logic signed [31:0]  right_ticks,
  input  logic signed [31:0]  heading,
  output logic                status,
  output logic signed [47:0]  pose_x,
  output logic signed [47:0]  pose_y,
  output logic signed [39:0]  pose_heading,
  output logic signed [39:0]  linear_velocity,
  output logic signed [31:0]  angular_velocity,
  output logic signed [47:0]  left_angle,
  output logic signed [47:0]  right_angle,
  output logic signed [31:0]  left_rate,
  output logic signed [31:0]  right_rate
);

  // request registers
  logic [31:0]        t_r;
  logic signed [31:0] lt_r, rt_r, h_r;
  logic signed [32:0] dt_r;
  logic               zero_r;

  // pose state
  logic signed [31:0] last_r;
  logic signed [47:0] x_r, y_r, la_r, ra_r;
  logic signed [39:0] hs_r;

  // multiplier and intermediates
  logic [31:0]        a_op, b_op;
  logic [63:0]        prod_r, plo_r;
  logic [62:0]        wl_mag_r, wr_mag_r;
  logic [59:0]        ssum_mag_r;
  logic               ssum_neg_r;
  logic signed [47:0] ds_r, dx_r, dy_r;

  // angle reduction and cordic
  logic [40:0]        red_m_r;
  logic               ang_neg_r;
  logic signed [33:0] cx_r, cy_r, cr_r;
  logic               flip_r;

  // divider lanes
  logic [75:0]        dnum_r [odo_pkg::DIV_LANES];
  logic [31:0]        drem_r [odo_pkg::DIV_LANES];
  logic [75:0]        dnum_nxt [odo_pkg::DIV_LANES];
  logic [31:0]        drem_nxt [odo_pkg::DIV_LANES];
  logic [32:0]        dtr [odo_pkg::DIV_LANES];
  logic               dge [odo_pkg::DIV_LANES];

  logic [31:0]        lt_abs, rt_abs;
  logic [47:0]        ds_mag;
  logic [32:0]        dt_abs;
  logic signed [60:0] wl28_cap, wr28_cap, ssum;
  logic [60:0]        ssum_abs;
  logic signed [60:0] wl28_s, wr28_s;
  logic [91:0]        full_s;
  logic [79:0]        full_p;
  logic signed [33:0] cval, sval;
  logic               c_neg, s_neg;
  logic [31:0]        cmag, smag;
  logic signed [32:0] half_dt;
  logic signed [40:0] ang;
  logic [41:0]        red_sub;
  logic signed [33:0] r0, r1, r2;
  logic               flip_c;
  logic signed [33:0] tx, ty;
  logic [27:0]        at;

  assign sts.t_zero = (step_dt == 32'd0);

  assign lt_abs = lt_r[31] ? 32'(-lt_r) : lt_r;
  assign rt_abs = rt_r[31] ? 32'(-rt_r) : rt_r;
  assign ds_mag = ds_r[47] ? 48'(-ds_r) : ds_r;
  assign dt_abs = dt_r[32] ? 33'(-dt_r) : dt_r;

  assign cval  = flip_r ? 34'(-cx_r) : cx_r;
  assign sval  = flip_r ? 34'(-cy_r) : cy_r;
  assign c_neg = cval[33];
  assign s_neg = sval[33];
  assign cmag  = c_neg ? 32'(-cval) : cval[31:0];
  assign smag  = s_neg ? 32'(-sval) : sval[31:0];

  always_comb begin
    unique case (cmd.mop)
      odo_pkg::MOP_WL:  begin a_op = lt_abs;                     b_op = radians_per_tick; end
      odo_pkg::MOP_WR:  begin a_op = rt_abs;                     b_op = radians_per_tick; end
      odo_pkg::MOP_SLO: begin a_op = ssum_mag_r[31:0];           b_op = radius_q16;       end
      odo_pkg::MOP_SHI: begin a_op = {4'b0, ssum_mag_r[59:32]};  b_op = radius_q16;       end
      odo_pkg::MOP_XLO: begin a_op = ds_mag[31:0];               b_op = cmag;             end
      odo_pkg::MOP_XHI: begin a_op = {16'b0, ds_mag[47:32]};     b_op = cmag;             end
      odo_pkg::MOP_YLO: begin a_op = ds_mag[31:0];               b_op = smag;             end
      odo_pkg::MOP_YHI: begin a_op = {16'b0, ds_mag[47:32]};     b_op = smag;             end
      default:          begin a_op = '0;                         b_op = '0;               end
    endcase
  end

  // wheel steps truncated to q.28
  always_comb begin
    wl28_cap = lt_r[31] ? -$signed({2'b0, wl_mag_r[62:4]}) : $signed({2'b0, wl_mag_r[62:4]});
    wr28_cap = rt_r[31] ? -$signed({2'b0, prod_r[62:4]}) : $signed({2'b0, prod_r[62:4]});
    ssum     = wl28_cap + wr28_cap;
    ssum_abs = ssum[60] ? 61'(-ssum) : ssum;
    wl28_s   = wl28_cap;
    wr28_s   = rt_r[31] ? -$signed({2'b0, wr_mag_r[62:4]}) : $signed({2'b0, wr_mag_r[62:4]});
    full_s   = {prod_r[59:0], 32'b0} + {28'b0, plo_r};
    full_p   = {prod_r[47:0], 32'b0} + {16'b0, plo_r};
  end

  // midpoint heading, range reduction and cordic step terms
  always_comb begin
    half_dt = dt_r[32] ? -$signed({1'b0, dt_abs[32:1]}) : $signed({1'b0, dt_abs[32:1]});
    ang     = {hs_r[39], hs_r} + {{8{half_dt[32]}}, half_dt};
    red_sub = odo_pkg::TWO_PI_W << cmd.red_k;
    r0      = ang_neg_r ? -$signed({3'b0, red_m_r[30:0]}) : $signed({3'b0, red_m_r[30:0]});
    if (r0 > odo_pkg::Q28_PI) begin
      r1 = r0 - odo_pkg::Q28_TWO_PI;
    end else if (r0 < -odo_pkg::Q28_PI) begin
      r1 = r0 + odo_pkg::Q28_TWO_PI;
    end else begin
      r1 = r0;
    end
    flip_c = 1'b1;
    if (r1 > odo_pkg::Q28_HALF_PI) begin
      r2 = r1 - odo_pkg::Q28_PI;
    end else if (r1 < -odo_pkg::Q28_HALF_PI) begin
      r2 = r1 + odo_pkg::Q28_PI;
    end else begin
      r2     = r1;
      flip_c = 1'b0;
    end
    tx = odo_pkg::tshr34(cy_r, cmd.cor_idx);
    ty = odo_pkg::tshr34(cx_r, cmd.cor_idx);
    at = odo_pkg::atan_q28(cmd.cor_idx);
  end

  always_comb begin
    for (int l = 0; l < odo_pkg::DIV_LANES; l++) begin
      dtr[l]      = {drem_r[l], dnum_r[l][75]};
      dge[l]      = dtr[l] >= {1'b0, t_r};
      drem_nxt[l] = dge[l] ? 32'(dtr[l] - {1'b0, t_r}) : dtr[l][31:0];
      dnum_nxt[l] = {dnum_r[l][74:0], dge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r    <= step_dt;
      lt_r   <= left_ticks;
      rt_r   <= right_ticks;
      h_r    <= heading;
      dt_r   <= {heading[31], heading} - {last_r[31], last_r};
      zero_r <= (step_dt == 32'd0);
    end
    if (cmd.mul_iss) begin
      prod_r <= {32'b0, a_op} * {32'b0, b_op};
    end
    if (cmd.mul_cap) begin
      unique case (cmd.mop)
        odo_pkg::MOP_WL: wl_mag_r <= prod_r[62:0];
        odo_pkg::MOP_WR: begin
          wr_mag_r   <= prod_r[62:0];
          ssum_neg_r <= ssum[60];
          ssum_mag_r <= ssum_abs[59:0];
        end
        odo_pkg::MOP_SLO, odo_pkg::MOP_XLO, odo_pkg::MOP_YLO: plo_r <= prod_r;
        odo_pkg::MOP_SHI:
          ds_r <= 48'(odo_pkg::make_signed(ssum_neg_r, {13'b0, full_s[91:29]}, 7'd48));
        odo_pkg::MOP_XHI:
          dx_r <= 48'(odo_pkg::make_signed(ds_r[47] ^ c_neg, {26'b0, full_p[79:30]}, 7'd48));
        odo_pkg::MOP_YHI:
          dy_r <= 48'(odo_pkg::make_signed(ds_r[47] ^ s_neg, {26'b0, full_p[79:30]}, 7'd48));
        default: plo_r <= plo_r;
      endcase
    end
    if (cmd.red_init) begin
      ang_neg_r <= ang[40];
      red_m_r   <= ang[40] ? 41'(-ang) : ang;
    end else if (cmd.red_step) begin
      if ({1'b0, red_m_r} >= red_sub) red_m_r <= red_m_r - red_sub[40:0];
    end
    if (cmd.cor_init) begin
      cx_r   <= odo_pkg::CORDIC_GAIN;
      cy_r   <= '0;
      cr_r   <= r2;
      flip_r <= flip_c;
    end else if (cmd.cor_step) begin
      if (!cr_r[33]) begin
        cx_r <= cx_r - tx;
        cy_r <= cy_r + ty;
        cr_r <= cr_r - $signed({6'b0, at});
      end else begin
        cx_r <= cx_r + tx;
        cy_r <= cy_r - ty;
        cr_r <= cr_r + $signed({6'b0, at});
      end
    end
    if (cmd.div_init) begin
      dnum_r[odo_pkg::LANE_LV] <= {4'b0, ds_mag, 24'b0};
      dnum_r[odo_pkg::LANE_AV] <= {27'b0, dt_abs, 16'b0};
      dnum_r[odo_pkg::LANE_LR] <= {1'b0, wl_mag_r, 12'b0};
      dnum_r[odo_pkg::LANE_RR] <= {1'b0, wr_mag_r, 12'b0};
      for (int l = 0; l < odo_pkg::DIV_LANES; l++) drem_r[l] <= '0;
    end else if (cmd.div_step) begin
      for (int l = 0; l < odo_pkg::DIV_LANES; l++) begin
        dnum_r[l] <= dnum_nxt[l];
        drem_r[l] <= drem_nxt[l];
      end
    end
    if (cmd.emit) begin
      status       <= zero_r;
      pose_x       <= x_r;
      pose_y       <= y_r;
      pose_heading <= hs_r;
      left_angle   <= la_r;
      right_angle  <= ra_r;
      if (zero_r) begin
        linear_velocity  <= '0;
        angular_velocity <= '0;
        left_rate        <= '0;
        right_rate       <= '0;
      end else begin
        linear_velocity  <= 40'(odo_pkg::make_signed(ds_r[47], dnum_r[odo_pkg::LANE_LV],
                                                     7'd40));
        angular_velocity <= 32'(odo_pkg::make_signed(dt_r[32], dnum_r[odo_pkg::LANE_AV],
                                                     7'd32));
        left_rate        <= 32'(odo_pkg::make_signed(lt_r[31], dnum_r[odo_pkg::LANE_LR],
                                                     7'd32));
        right_rate       <= 32'(odo_pkg::make_signed(rt_r[31], dnum_r[odo_pkg::LANE_RR],
                                                     7'd32));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      x_r    <= '0;
      y_r    <= '0;
      hs_r   <= '0;
      la_r   <= '0;
      ra_r   <= '0;
    end else if (cmd.update) begin
      last_r <= h_r;
      x_r    <= 48'(odo_pkg::sat_s(64'(x_r) + 64'(dx_r), 7'd48));
      y_r    <= 48'(odo_pkg::sat_s(64'(y_r) + 64'(dy_r), 7'd48));
      hs_r   <= 40'(odo_pkg::sat_s(64'(hs_r) + 64'(dt_r), 7'd40));
      la_r   <= 48'(odo_pkg::sat_s(64'(la_r) + 64'(wl28_s), 7'd48));
      ra_r   <= 48'(odo_pkg::sat_s(64'(ra_r) + 64'(wr28_s), 7'd48));
    end
  end

endmodule

// File: dv/tb_odometry_pose_integrator.sv
// testbench for the odometry pose integrator: random and directed requests checked against a
// fixed-point pose predictor; depends on odometry_pose_integrator, odo_pkg, odo_in_if, odo_out_if
`timescale 1ns / 1ps

module tb_odometry_pose_integrator;

  localparam int LIMIT_CYCLES = 2000000;
  localparam logic [odo_pkg::CFG_AW-1:0] ADDR_RADIUS =
    odo_pkg::CFG_AW'(4 * odo_pkg::REG_RADIUS);
  localparam logic [odo_pkg::CFG_AW-1:0] ADDR_RPT =
    odo_pkg::CFG_AW'(4 * odo_pkg::REG_RAD_PER_TICK);

  typedef struct {
    logic        status;
    logic [47:0] px;
    logic [47:0] py;
    logic [39:0] ph;
    logic [39:0] lv;
    logic [31:0] av;
    logic [47:0] la;
    logic [47:0] ra;
    logic [31:0] lr;
    logic [31:0] rr;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [odo_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  odo_in_if in_ch ();
  odo_out_if out_ch ();

  odometry_pose_integrator i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [31:0] m_radius, m_rpt;
  longint m_last_h, m_x, m_y, m_hsum, m_lsum, m_rsum;

  pose_t pose_q[$];
  int errors = 0;
  int cycles = 0;
  bit idle_in = 1'b1;
  bit idle_out = 1'b1;
  bit hold_out = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint umag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint shr_tz(longint v, int s);
    return v < 0 ? -(umag(v) >>> s) : v >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint sgn_sat(bit neg, logic [63:0] mag, int w);
    logic [63:0] lim;
    lim = 64'd1 << (w - 1);
    if (mag >= lim) return neg ? -longint'(lim) : longint'(lim - 1);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [31:0] b, int s);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> s;
    return p[127:64] != 0 ? '1 : p[63:0];
  endfunction

  function automatic logic [63:0] div_frac(logic [63:0] a, logic [31:0] d, int s);
    logic [127:0] q;
    q = (128'(a) << s) / 128'(d);
    return q > 128'(64'd1 << 62) ? (64'd1 << 62) : q[63:0];
  endfunction

  function automatic longint atan_tab(int i);
    longint t[29] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
      4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return i < 29 ? t[i] : 0;
  endfunction

  task automatic sin_cos(input longint ang, output longint c, output longint s);
    longint r, x, y, nx;
    bit flip;
    r = ang % 1686629713;
    x = 652032874;
    y = 0;
    flip = 0;
    if (r > 843314857) r -= 1686629713;
    else if (r < -843314857) r += 1686629713;
    if (r > 421657428) begin
      r -= 843314857; flip = 1;
    end else if (r < -421657428) begin
      r += 843314857; flip = 1;
    end
    for (int i = 0; i < odo_pkg::CORDIC_STEPS; i++) begin
      if (r >= 0) begin
        nx = x - shr_tz(y, i); y = y + shr_tz(x, i); r -= atan_tab(i);
      end else begin
        nx = x + shr_tz(y, i); y = y - shr_tz(x, i); r += atan_tab(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_pose(input logic [31:0] t, input logic [31:0] lt,
                              input logic [31:0] rt, input logic [31:0] hd);
    pose_t p;
    longint h, wl, wr, wl28, wr28, ssum, ds, dth, c, s, dx, dy, lv, av, lr, rr;
    lv = 0; av = 0; lr = 0; rr = 0;
    p.status = 1'b1;
    if (t != 0) begin
      h = longint'($signed(hd));
      wl = longint'($signed(lt)); wl = wl < 0 ? -(umag(wl) * m_rpt) : wl * m_rpt;
      wr = longint'($signed(rt)); wr = wr < 0 ? -(umag(wr) * m_rpt) : wr * m_rpt;
      wl28 = shr_tz(wl, 4);
      wr28 = shr_tz(wr, 4);
      ssum = wl28 + wr28;
      ds = sgn_sat(ssum < 0, mul_shift(umag(ssum), m_radius, 29), 48);
      dth = h - m_last_h;
      sin_cos(m_hsum + shr_tz(dth, 1), c, s);
      dx = sgn_sat((ds < 0) != (c < 0), mul_shift(umag(ds), 32'(umag(c)), 30), 48);
      dy = sgn_sat((ds < 0) != (s < 0), mul_shift(umag(ds), 32'(umag(s)), 30), 48);
      m_x = clamp(m_x + dx, 48);
      m_y = clamp(m_y + dy, 48);
      m_hsum = clamp(m_hsum + dth, 40);
      m_lsum = clamp(m_lsum + wl28, 48);
      m_rsum = clamp(m_rsum + wr28, 48);
      lv = sgn_sat(ds < 0, div_frac(umag(ds), t, 24), 40);
      av = sgn_sat(dth < 0, div_frac(umag(dth), t, 16), 32);
      lr = sgn_sat(wl < 0, div_frac(umag(wl), t, 12), 32);
      rr = sgn_sat(wr < 0, div_frac(umag(wr), t, 12), 32);
      m_last_h = h;
      p.status = 1'b0;
    end
    p.px = m_x[47:0]; p.py = m_y[47:0]; p.ph = m_hsum[39:0];
    p.lv = lv[39:0]; p.av = av[31:0]; p.la = m_lsum[47:0]; p.ra = m_rsum[47:0];
    p.lr = lr[31:0]; p.rr = rr[31:0];
    pose_q.push_back(p);
  endtask

  task automatic send_step(input logic [31:0] t, input logic [31:0] lt,
                           input logic [31:0] rt, input logic [31:0] hd);
    while (idle_in && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.step_dt <= t;
    in_ch.left_ticks <= lt;
    in_ch.right_ticks <= rt;
    in_ch.heading <= hd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_pose(t, lt, rt, hd);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [odo_pkg::CFG_AW-1:0] addr, input logic [31:0] value);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == ADDR_RADIUS) m_radius = value;
    else m_rpt = value;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] radius, input logic [31:0] rpt);
    drain();
    write_reg(ADDR_RADIUS, radius);
    write_reg(ADDR_RPT, rpt);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    configure(32'd65536 * 30, 32'd4294967);
    send_step(32'd0, 32'd100, 32'd100, 32'd0);
    send_step(32'd1 << 20, 32'd100, 32'd100, 32'd0);
    send_step(32'd1 << 20, 32'd200, -32'd50, 32'h1000_0000);
    send_step(32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_step(32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_step(32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
    send_step(32'd1 << 24, -32'd1000, 32'd1000, 32'h3243_f6a9);
    send_step(32'd1 << 24, 32'd1000, 32'd1000, -32'h3243_f6a9);
    configure(32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 8; i++)
      send_step(32'd1, 32'h7fff_ffff, 32'h7fff_ffff, i[0] ? 32'h7fff_ffff : 32'h8000_0000);
    for (int i = 0; i < 4; i++)
      send_step(32'd1, 32'h8000_0000, 32'h8000_0000, 32'h0);
    configure(32'd0, 32'd0);
    send_step(32'd1000, 32'd5, 32'd5, 32'd5);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_step($urandom_range(15) == 0 ? 32'd0 : rand_field(),
                rand_field(), rand_field(), $urandom);
    end
  endtask

  task automatic test_output_stall;
    hold_out = 1'b1;
    for (int i = 0; i < 6; i++) send_step($urandom | 1, $urandom, $urandom, $urandom);
    hold_out = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.step_dt = '0; in_ch.left_ticks = '0; in_ch.right_ticks = '0;
    in_ch.heading = '0;
    out_ch.ready = 1'b0;
    m_radius = '0; m_rpt = '0;
    m_last_h = 0; m_x = 0; m_y = 0; m_hsum = 0; m_lsum = 0; m_rsum = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    configure($urandom, $urandom);
    test_random(500);
    idle_in = 1'b0;
    idle_out = 1'b0;
    test_random(300);
    idle_in = 1'b1;
    idle_out = 1'b1;
    test_output_stall();
    configure(32'd65536 * 35, 32'd10000000);
    test_random(400);
    configure($urandom, $urandom);
    test_random(400);
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver ready with random stalls and one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_out = 1'b0;
      end
      out_ch.ready <= !(idle_out && $urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin
    pose_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pose_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status exp %h got %h", e.status, out_ch.status); errors++;
        end
        if (out_ch.pose_x !== e.px) begin
          $error("pose_x exp %h got %h", e.px, out_ch.pose_x); errors++;
        end
        if (out_ch.pose_y !== e.py) begin
          $error("pose_y exp %h got %h", e.py, out_ch.pose_y); errors++;
        end
        if (out_ch.pose_heading !== e.ph) begin
          $error("pose_heading exp %h got %h", e.ph, out_ch.pose_heading); errors++;
        end
        if (out_ch.linear_velocity !== e.lv) begin
          $error("linear_velocity exp %h got %h", e.lv, out_ch.linear_velocity); errors++;
        end
        if (out_ch.angular_velocity !== e.av) begin
          $error("angular_velocity exp %h got %h", e.av, out_ch.angular_velocity); errors++;
        end
        if (out_ch.left_angle !== e.la) begin
          $error("left_angle exp %h got %h", e.la, out_ch.left_angle); errors++;
        end
        if (out_ch.right_angle !== e.ra) begin
          $error("right_angle exp %h got %h", e.ra, out_ch.right_angle); errors++;
        end
        if (out_ch.left_rate !== e.lr) begin
          $error("left_rate exp %h got %h", e.lr, out_ch.left_rate); errors++;
        end
        if (out_ch.right_rate !== e.rr) begin
          $error("right_rate exp %h got %h", e.rr, out_ch.right_rate); errors++;
        end
      end
    end
  end

endmodule

// File: files.f
rtl/core/odo_pkg.sv
rtl/core/odo_in_if.sv
rtl/core/odo_out_if.sv
rtl/core/odo_ctrl.sv
rtl/core/odo_dp.sv
rtl/core/odometry_pose_integrator.sv
dv/tb_odometry_pose_integrator.sv
